@@ hw/rtl/dhm_pkg.sv @@
`default_nettype none

package dhm_pkg;

    // number of setup registers and the default number of channels
    localparam int NUM_SETUP_REGS   = 8;
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int SETUP_W          = 29;
    localparam int SETUP_IDX_W      = 3;
    localparam int QUEUE_DEPTH      = 2;

    // input word kinds
    localparam logic KIND_SCAN    = 1'b0;
    localparam logic KIND_ARRIVAL = 1'b1;

    // worst_channel code when no channel is lost
    localparam logic [3:0] NONE_CHANNEL = 4'd8;

    // setup values after reset, channel 7 disabled
    localparam logic [NUM_SETUP_REGS-1:0][SETUP_W-1:0] SETUP_RESET = {
        29'd0,
        29'd471810548,
        29'd423527400,
        29'd436224070,
        29'd469774386,
        29'd453025797,
        29'd486551582,
        29'd503328798
    };

    typedef struct packed {
        logic        kind;
        logic [2:0]  channel;
        logic [31:0] now;
        logic        data_error;
    } in_t;

    typedef struct packed {
        logic [2:0]  channel_id;
        logic        enabled;
        logic        lost;
        logic        has_error;
        logic        data_error_flag;
        logic        lost_action;
        logic        data_error_action;
        logic [31:0] period;
        logic [3:0]  worst_channel;
        logic        any_lost;
        logic        last;
    } out_t;

    // classified command handed from front to back
    typedef struct packed {
        logic        is_scan;
        logic [2:0]  channel;
        logic [31:0] now;
        logic        data_error;
    } cmd_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } back_state_t;

    function automatic logic [11:0] setup_limit(input logic [SETUP_W-1:0] s);
        return s[11:0];
    endfunction

    function automatic logic [11:0] setup_warmup(input logic [SETUP_W-1:0] s);
        return s[23:12];
    endfunction

    function automatic logic [3:0] setup_priority(input logic [SETUP_W-1:0] s);
        return s[27:24];
    endfunction

    function automatic logic setup_enable(input logic [SETUP_W-1:0] s);
        return s[28];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dhm_front.sv @@
`default_nettype none

module dhm_front
    import dhm_pkg::*;
#(
    parameter int NCH = NUM_CHANNELS_DEF
)(
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_word,
    input  wire logic q_full,
    output logic      q_push,
    output cmd_t      q_word
);

    logic is_scan;
    logic chan_ok;

    always_comb
    begin
        is_scan  = (in_word.kind == KIND_SCAN);
        // arrivals on channels that do not exist are dropped here
        chan_ok  = ({1'b0, in_word.channel} < 4'(NCH));
        in_ready = !q_full;
        q_push   = in_valid && !q_full && (is_scan || chan_ok);
        q_word.is_scan    = is_scan;
        q_word.channel    = in_word.channel;
        q_word.now        = in_word.now;
        q_word.data_error = in_word.data_error;
    end

endmodule

`default_nettype wire

@@ hw/rtl/dhm_queue.sv @@
`default_nettype none

module dhm_queue
    import dhm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_word,
    output logic      full,
    input  wire logic pop,
    output logic      valid,
    output cmd_t      head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        full  = (count_reg == CNT_W'(QUEUE_DEPTH));
        valid = (count_reg != '0);
        head  = entry_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dhm_back.sv @@
`default_nettype none

module dhm_back
    import dhm_pkg::*;
#(
    parameter int NCH = NUM_CHANNELS_DEF
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [SETUP_IDX_W-1:0] cfg_index,
    input  wire logic [SETUP_W-1:0]     cfg_data,
    input  wire logic                   q_valid,
    input  wire cmd_t                   q_word,
    output logic                        q_pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_t                        out_word
);

    localparam int CIDX_W = (NCH > 1) ? $clog2(NCH) : 1;

    logic [SETUP_W-1:0] setup_reg [NUM_SETUP_REGS];

    logic [31:0] newest_reg [NCH];
    logic [31:0] prev_reg   [NCH];
    logic [31:0] online_reg [NCH];
    logic        lost_reg   [NCH];
    logic        err_reg    [NCH];
    logic        bad_reg    [NCH];

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [CIDX_W-1:0] cnt_reg;
    logic [CIDX_W-1:0] cnt_next;
    logic [31:0]       now_reg;
    logic [31:0]       now_next;
    logic              have_worst_reg;
    logic              have_worst_next;
    logic [3:0]        worst_reg;
    logic [3:0]        worst_next;
    logic [3:0]        worst_pri_reg;
    logic [3:0]        worst_pri_next;
    logic              any_reg;
    logic              any_next;
    out_t              out_reg;
    out_t              out_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    // write-back of the selected channel
    logic        wr_en;
    logic [31:0] newest_next;
    logic [31:0] prev_next;
    logic [31:0] online_next;
    logic        lost_next;
    logic        err_next;
    logic        bad_next;

    logic [CIDX_W-1:0]  cidx;
    logic [SETUP_W-1:0] setup;
    logic [31:0]        elapsed;
    logic [31:0]        since_online;
    logic               offline;
    logic               warming;
    logic [31:0]        period_calc;
    logic               can_emit;
    logic               take_worst;

    always_comb
    begin
        cidx = (state_reg == ST_SCAN) ? cnt_reg : q_word.channel[CIDX_W-1:0];
        setup = setup_reg[SETUP_IDX_W'(cidx)];
        elapsed      = now_reg - newest_reg[cidx];
        since_online = now_reg - online_reg[cidx];
        offline = elapsed > {20'd0, setup_limit(setup)};
        warming = since_online < {20'd0, setup_warmup(setup)};
        period_calc = (newest_reg[cidx] > prev_reg[cidx]) ?
                      newest_reg[cidx] - prev_reg[cidx] : 32'd0;
        take_worst = !have_worst_reg || (setup_priority(setup) > worst_pri_reg);
        can_emit = !out_valid_reg || out_ready;

        state_next      = state_reg;
        cnt_next        = cnt_reg;
        now_next        = now_reg;
        have_worst_next = have_worst_reg;
        worst_next      = worst_reg;
        worst_pri_next  = worst_pri_reg;
        any_next        = any_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        newest_next     = newest_reg[cidx];
        prev_next       = prev_reg[cidx];
        online_next     = online_reg[cidx];
        lost_next       = lost_reg[cidx];
        err_next        = err_reg[cidx];
        bad_next        = bad_reg[cidx];
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        out_next.channel_id        = 3'(cidx);
        out_next.enabled           = setup_enable(setup);
        out_next.lost_action       = 1'b0;
        out_next.data_error_action = 1'b0;
        out_next.period            = 32'd0;
        out_next.worst_channel     = NONE_CHANNEL;
        out_next.any_lost          = 1'b0;
        out_next.last              = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && can_emit)
                begin
                    q_pop = 1'b1;
                    if (q_word.is_scan)
                    begin
                        state_next      = ST_SCAN;
                        cnt_next        = '0;
                        now_next        = q_word.now;
                        have_worst_next = 1'b0;
                        worst_next      = NONE_CHANNEL;
                        worst_pri_next  = 4'd0;
                        any_next        = 1'b0;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        prev_next   = newest_reg[cidx];
                        newest_next = q_word.now;
                        if (lost_reg[cidx])
                        begin
                            lost_next   = 1'b0;
                            online_next = q_word.now;
                        end
                        bad_next = q_word.data_error;
                        if (q_word.data_error)
                        begin
                            err_next = 1'b1;
                        end
                        out_valid_next             = 1'b1;
                        out_next.data_error_action = q_word.data_error;
                        out_next.last              = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (can_emit)
                begin
                    wr_en = 1'b1;
                    if (setup_enable(setup))
                    begin
                        if (offline)
                        begin
                            if (!err_reg[cidx])
                            begin
                                lost_next = 1'b1;
                                err_next  = 1'b1;
                            end
                            if (take_worst)
                            begin
                                have_worst_next = 1'b1;
                                worst_next      = 4'(cidx);
                                worst_pri_next  = setup_priority(setup);
                            end
                            any_next             = 1'b1;
                            out_next.lost_action = 1'b1;
                        end
                        else if (warming)
                        begin
                            lost_next = 1'b0;
                            err_next  = 1'b1;
                        end
                        else
                        begin
                            lost_next       = 1'b0;
                            err_next        = bad_reg[cidx];
                            out_next.period = period_calc;
                        end
                    end
                    out_valid_next = 1'b1;
                    if (cnt_reg == CIDX_W'(NCH - 1))
                    begin
                        state_next             = ST_IDLE;
                        out_next.last          = 1'b1;
                        out_next.worst_channel = worst_next;
                        out_next.any_lost      = any_next;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_next.lost            = lost_next;
        out_next.has_error       = err_next;
        out_next.data_error_flag = bad_next;
        if (!(out_valid_next && !(out_valid_reg && !out_ready)))
        begin
            out_next = out_reg;
        end

        out_valid = out_valid_reg;
        out_word  = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            have_worst_reg <= 1'b0;
            worst_reg      <= NONE_CHANNEL;
            worst_pri_reg  <= 4'd0;
            any_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_SETUP_REGS; i++)
            begin
                setup_reg[i] <= SETUP_RESET[i];
            end
            for (int i = 0; i < NCH; i++)
            begin
                newest_reg[i] <= 32'd0;
                prev_reg[i]   <= 32'd0;
                online_reg[i] <= 32'd0;
                lost_reg[i]   <= 1'b1;
                err_reg[i]    <= 1'b1;
                bad_reg[i]    <= 1'b1;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            have_worst_reg <= have_worst_next;
            worst_reg      <= worst_next;
            worst_pri_reg  <= worst_pri_next;
            any_reg        <= any_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                setup_reg[cfg_index] <= cfg_data;
            end
            if (wr_en)
            begin
                newest_reg[cidx] <= newest_next;
                prev_reg[cidx]   <= prev_next;
                online_reg[cidx] <= online_next;
                lost_reg[cidx]   <= lost_next;
                err_reg[cidx]    <= err_next;
                bad_reg[cidx]    <= bad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/device_heartbeat_monitor_unit.sv @@
// Per-channel heartbeat watchdog. An arrival word (kind = 1) stamps its
// channel with the tick in now, ends a lost spell by restarting the warm-up
// window, latches data_error and returns one status word with last set. An
// arrival on a channel that does not exist is dropped and returns nothing. A
// scan word (kind = 0) returns one status word per channel in index order;
// each enabled channel is judged offline, warming up or healthy, and the
// last word carries the highest-priority lost channel (8 for none) and
// any_lost. Accepted words wait in a two-entry queue between the input side
// and the channel sequencer, and results leave through an output register,
// so the input keeps taking words while a result waits. Timing: the
// sequencer handles one channel per cycle against the shared per-channel
// state, and a stalled output holds the sequencer. Setup registers are
// written through cfg_we, cfg_index and cfg_data with no wait; the user must
// write them only while the block is idle, which the block does not enforce.
`default_nettype none

module device_heartbeat_monitor_unit
    import dhm_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // setup register write port
    input  wire logic                   cfg_we,
    input  wire logic [SETUP_IDX_W-1:0] cfg_index,
    input  wire logic [SETUP_W-1:0]     cfg_data,
    // input words
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_t                    in_word,
    // status words
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_t                        out_word
);

    // only channels below the number of setup registers can exist
    localparam int NCH = (NUM_CHANNELS < NUM_SETUP_REGS) ? NUM_CHANNELS : NUM_SETUP_REGS;

    // front to queue
    logic q_push;
    cmd_t q_push_word;
    logic q_full;
    // queue to back
    logic q_pop;
    logic q_valid;
    cmd_t q_head;

    // front: takes input words and drops arrivals on missing channels
    dhm_front #(
        .NCH (NCH)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_word   (q_push_word)
    );

    // short queue so the front keeps accepting while a scan runs
    dhm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_push_word),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    // back: channel state, setup registers, scan sequencer, output register
    dhm_back #(
        .NCH (NCH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_word    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // the sequencer never takes a word from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("queue popped while empty");

    // only the closing word of a run reports the worst channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_word.last) |->
        (out_word.worst_channel == NONE_CHANNEL && !out_word.any_lost))
        else $error("worst channel reported before end of scan");

    // a data-error action only comes from an arrival, which is a single word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.data_error_action) |->
        (out_word.last && !out_word.lost_action && out_word.period == 32'd0))
        else $error("data-error action on a scan word");

    // a lost action only for an enabled channel that is now marked in error
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.lost_action) |->
        (out_word.enabled && out_word.has_error))
        else $error("lost action on disabled or error-free channel");

endmodule

`default_nettype wire
